@@ hdl/rauc_pkg.sv @@
// shared types and constants for the raw audio unit converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rauc_pkg;

    localparam int ValW     = 64;
    localparam int BpfW     = 10;
    localparam int RateW    = 20;
    localparam int NumW     = 30;
    localparam int DenW     = 30;
    localparam int ProdW    = ValW + NumW;
    localparam int HalfW    = ValW / 2;
    localparam int UnitW    = 2;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 20;

    typedef enum logic [UnitW-1:0] {
        UNIT_BYTES  = 2'd0,
        UNIT_FRAMES = 2'd1,
        UNIT_NS     = 2'd2,
        UNIT_OTHER  = 2'd3
    } t_unit;

    localparam logic [CfgIdxW-1:0] CFG_BYTES_PER_FRAME = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_SAMPLE_RATE     = 1'd1;

    localparam logic [NumW-1:0] NS_PER_SEC = 30'd1000000000;

    // per-item control that travels with the data
    typedef struct packed {
        logic ok;   // result is valid
        logic neg;  // negate the quotient at the end
        logic mul;  // multiply only, high product bits dropped
        logic ovf;  // quotient does not fit, result is all ones
    } t_ctrl;

endpackage

`default_nettype wire

@@ hdl/rauc_decode.sv @@
// input stage: unit pair decode, operand and divisor selection
// depends on rauc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rauc_decode
    import rauc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [UnitW-1:0] i_src,
    input  wire logic [UnitW-1:0] i_dst,
    input  wire logic [ValW-1:0]  i_value,
    input  wire logic [BpfW-1:0]  i_bpf,
    input  wire logic [RateW-1:0] i_rate,
    output logic                  o_valid,
    output t_ctrl                 o_ctrl,
    output logic [ValW-1:0]       o_u,
    output logic [NumW-1:0]       o_num,
    output logic [DenW-1:0]       o_den
);

    logic            r_valid;
    t_ctrl           r_ctrl, n_ctrl;
    logic [ValW-1:0] r_u, n_u;
    logic [NumW-1:0] r_num, n_num;
    logic [DenW-1:0] r_den, n_den;
    logic [DenW-1:0] byterate;
    logic            pass;
    logic            known;

    assign byterate = DenW'(i_bpf) * DenW'(i_rate);
    assign pass  = (i_src == i_dst) || (i_value == '0) || (i_value == '1);
    assign known = (i_bpf != '0) && (i_rate != '0);

    always_comb begin
        n_u     = '0;
        n_num   = NumW'(1);
        n_den   = DenW'(1);
        n_ctrl  = '{ok: 1'b0, neg: 1'b0, mul: 1'b1, ovf: 1'b0};
        if (pass) begin
            n_u       = i_value;
            n_ctrl.ok = 1'b1;
        end else if (known) begin
            if (i_src == UNIT_BYTES && i_dst == UNIT_FRAMES) begin
                // magnitude divide, sign fixed at the end (truncates to zero)
                n_u        = i_value[ValW-1] ? (~i_value + ValW'(1)) : i_value;
                n_den      = DenW'(i_bpf);
                n_ctrl.ok  = 1'b1;
                n_ctrl.mul = 1'b0;
                n_ctrl.neg = i_value[ValW-1];
            end else if (i_src == UNIT_BYTES && i_dst == UNIT_NS) begin
                n_u        = i_value;
                n_num      = NS_PER_SEC;
                n_den      = byterate;
                n_ctrl.ok  = 1'b1;
                n_ctrl.mul = 1'b0;
            end else if (i_src == UNIT_FRAMES && i_dst == UNIT_BYTES) begin
                n_u       = i_value;
                n_num     = NumW'(i_bpf);
                n_ctrl.ok = 1'b1;
            end else if (i_src == UNIT_FRAMES && i_dst == UNIT_NS) begin
                n_u        = i_value;
                n_num      = NS_PER_SEC;
                n_den      = DenW'(i_rate);
                n_ctrl.ok  = 1'b1;
                n_ctrl.mul = 1'b0;
            end else if (i_src == UNIT_NS && i_dst == UNIT_BYTES) begin
                n_u        = i_value;
                n_num      = byterate;
                n_den      = NS_PER_SEC;
                n_ctrl.ok  = 1'b1;
                n_ctrl.mul = 1'b0;
            end else if (i_src == UNIT_NS && i_dst == UNIT_FRAMES) begin
                n_u        = i_value;
                n_num      = NumW'(i_rate);
                n_den      = NS_PER_SEC;
                n_ctrl.ok  = 1'b1;
                n_ctrl.mul = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctrl <= n_ctrl;
            r_u    <= n_u;
            r_num  <= n_num;
            r_den  <= n_den;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_u     = r_u;
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule

`default_nettype wire

@@ hdl/rauc_mul.sv @@
// two-stage 64 x 30 multiplier: split partial products, then the sum
// depends on rauc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rauc_mul
    import rauc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire t_ctrl           i_ctrl,
    input  wire logic [ValW-1:0] i_u,
    input  wire logic [NumW-1:0] i_num,
    input  wire logic [DenW-1:0] i_den,
    output logic                 o_valid,
    output t_ctrl                o_ctrl,
    output logic [ProdW-1:0]     o_prod,
    output logic [DenW-1:0]      o_den
);

    localparam int PartW = HalfW + NumW;

    logic             r_valid1, r_valid2;
    t_ctrl            r_ctrl1, r_ctrl2;
    logic [DenW-1:0]  r_den1, r_den2;
    logic [PartW-1:0] r_plo, r_phi;
    logic [ProdW-1:0] r_prod, n_prod;

    always_comb begin
        n_prod = ProdW'(r_plo) + (ProdW'(r_phi) << HalfW);
        // plain multiply keeps only the low word
        if (r_ctrl1.mul) begin
            n_prod[ProdW-1:ValW] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
        if (i_en) begin
            r_plo   <= PartW'(i_u[HalfW-1:0]) * PartW'(i_num);
            r_phi   <= PartW'(i_u[ValW-1:HalfW]) * PartW'(i_num);
            r_ctrl1 <= i_ctrl;
            r_den1  <= i_den;
            r_prod  <= n_prod;
            r_ctrl2 <= r_ctrl1;
            r_den2  <= r_den1;
        end
    end

    assign o_valid = r_valid2;
    assign o_ctrl  = r_ctrl2;
    assign o_prod  = r_prod;
    assign o_den   = r_den2;

endmodule

`default_nettype wire

@@ hdl/rauc_div_step.sv @@
// one registered restoring-divide step, one quotient bit
// depends on rauc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rauc_div_step
    import rauc_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire t_ctrl           i_ctrl,
    input  wire logic [DenW-1:0] i_rem,
    input  wire logic [ValW-1:0] i_dvd,
    input  wire logic [DenW-1:0] i_den,
    output logic                 o_valid,
    output t_ctrl                o_ctrl,
    output logic [DenW-1:0]      o_rem,
    output logic [ValW-1:0]      o_dvd,
    output logic [DenW-1:0]      o_den
);

    logic            r_valid;
    t_ctrl           r_ctrl;
    logic [DenW-1:0] r_rem, n_rem;
    logic [ValW-1:0] r_dvd;
    logic [DenW-1:0] r_den;
    logic [DenW:0]   trial;
    logic            ge;

    assign trial = {i_rem, i_dvd[ValW-1]};
    assign ge    = trial >= {1'b0, i_den};
    assign n_rem = ge ? DenW'(trial - {1'b0, i_den}) : DenW'(trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctrl <= i_ctrl;
            r_rem  <= n_rem;
            // dividend bits shift out the top, quotient bits in at the bottom
            r_dvd  <= {i_dvd[ValW-2:0], ge};
            r_den  <= i_den;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_rem   = r_rem;
    assign o_dvd   = r_dvd;
    assign o_den   = r_den;

endmodule

`default_nettype wire

@@ hdl/rauc_div.sv @@
// pipelined 94 / 30 divider: overflow check stage then 64 step stages
// depends on rauc_pkg, rauc_div_step
`timescale 1ns / 1ps
`default_nettype none

module rauc_div
    import rauc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_ctrl            i_ctrl,
    input  wire logic [ProdW-1:0] i_prod,
    input  wire logic [DenW-1:0]  i_den,
    output logic                  o_valid,
    output t_ctrl                 o_ctrl,
    output logic [ValW-1:0]       o_quot
);

    logic            w_valid [0:ValW];
    t_ctrl           w_ctrl  [0:ValW];
    logic [DenW-1:0] w_rem   [0:ValW];
    logic [ValW-1:0] w_dvd   [0:ValW];
    logic [DenW-1:0] w_den   [0:ValW];

    logic            r_valid;
    t_ctrl           r_ctrl, n_ctrl;
    logic [DenW-1:0] r_rem;
    logic [ValW-1:0] r_dvd;
    logic [DenW-1:0] r_den;
    logic [DenW-1:0] hi;
    logic            ovf;

    // quotient of 2^64 or more when the high word already reaches the divisor
    assign hi  = i_prod[ProdW-1:ValW];
    assign ovf = hi >= i_den;

    always_comb begin
        n_ctrl     = i_ctrl;
        n_ctrl.ovf = ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctrl <= n_ctrl;
            r_rem  <= ovf ? '0 : hi;
            r_dvd  <= i_prod[ValW-1:0];
            r_den  <= i_den;
        end
    end

    assign w_valid[0] = r_valid;
    assign w_ctrl[0]  = r_ctrl;
    assign w_rem[0]   = r_rem;
    assign w_dvd[0]   = r_dvd;
    assign w_den[0]   = r_den;

    for (genvar g = 0; g < ValW; g++) begin : g_step
        rauc_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[g]),
            .i_ctrl  (w_ctrl[g]),
            .i_rem   (w_rem[g]),
            .i_dvd   (w_dvd[g]),
            .i_den   (w_den[g]),
            .o_valid (w_valid[g+1]),
            .o_ctrl  (w_ctrl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_dvd   (w_dvd[g+1]),
            .o_den   (w_den[g+1])
        );
    end

    assign o_valid = w_valid[ValW];
    assign o_ctrl  = w_ctrl[ValW];
    assign o_quot  = w_dvd[ValW];

endmodule

`default_nettype wire

@@ hdl/raw_audio_unit_convert.sv @@
// top level of the audio position unit converter: config registers,
// pipeline hookup and output register; depends on rauc_pkg, rauc_decode,
// rauc_mul, rauc_div
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata value, tuser units
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata value, tuser ok
//  cfg       in   i_cfg_we                           i_cfg_addr, i_cfg_wdata
//
//  one transfer per cycle sustained while the pipeline is not stalled
//  the divider has 64 stages, one quotient bit per stage
//  synchronous active-low reset clears config and all valid bits
//  a held result stalls the whole pipeline only when a new result is
//  ready behind it; bubbles still fill while the output waits

module raw_audio_unit_convert
    import rauc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [ValW-1:0]     i_s_axis_tdata,   // [63:0] source_value
    input  wire logic [2*UnitW-1:0]  i_s_axis_tuser,   // [1:0] source_unit, [3:2] target_unit
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    output logic [ValW-1:0]          o_m_axis_tdata,   // [63:0] converted_value
    output logic                     o_m_axis_tuser,   // [0] ok
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_addr,
    input  wire logic [CfgDataW-1:0] i_cfg_wdata
);

    // config registers
    logic [BpfW-1:0]  r_bpf;
    logic [RateW-1:0] r_rate;

    // stage links
    logic             dec_valid, mul_valid, div_valid;
    t_ctrl            dec_ctrl, mul_ctrl, div_ctrl;
    logic [ValW-1:0]  dec_u;
    logic [NumW-1:0]  dec_num;
    logic [DenW-1:0]  dec_den, mul_den;
    logic [ProdW-1:0] mul_prod;
    logic [ValW-1:0]  div_quot;

    // output register
    logic             r_out_valid;
    logic             r_out_ok;
    logic [ValW-1:0]  r_out_data, n_out_data;

    logic             en;

    // hold everything only when a finished result would overwrite a waiting one
    assign en = !(r_out_valid && !i_m_axis_tready && div_valid);
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpf  <= '0;
            r_rate <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BYTES_PER_FRAME: r_bpf  <= i_cfg_wdata[BpfW-1:0];
                CFG_SAMPLE_RATE:     r_rate <= i_cfg_wdata[RateW-1:0];
                default: ;
            endcase
        end
    end

    rauc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_src   (i_s_axis_tuser[UnitW-1:0]),
        .i_dst   (i_s_axis_tuser[2*UnitW-1:UnitW]),
        .i_value (i_s_axis_tdata),
        .i_bpf   (r_bpf),
        .i_rate  (r_rate),
        .o_valid (dec_valid),
        .o_ctrl  (dec_ctrl),
        .o_u     (dec_u),
        .o_num   (dec_num),
        .o_den   (dec_den)
    );

    rauc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dec_valid),
        .i_ctrl  (dec_ctrl),
        .i_u     (dec_u),
        .i_num   (dec_num),
        .i_den   (dec_den),
        .o_valid (mul_valid),
        .o_ctrl  (mul_ctrl),
        .o_prod  (mul_prod),
        .o_den   (mul_den)
    );

    // plain multiplies and pass-through run with divisor one
    rauc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mul_valid),
        .i_ctrl  (mul_ctrl),
        .i_prod  (mul_prod),
        .i_den   (mul_den),
        .o_valid (div_valid),
        .o_ctrl  (div_ctrl),
        .o_quot  (div_quot)
    );

    // final fixups: failures give zero, overflow saturates, byte-to-frame sign restored
    always_comb begin
        if (!div_ctrl.ok) begin
            n_out_data = '0;
        end else if (div_ctrl.ovf) begin
            n_out_data = '1;
        end else if (div_ctrl.neg) begin
            n_out_data = ~div_quot + ValW'(1);
        end else begin
            n_out_data = div_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && div_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (en && div_valid) begin
            r_out_ok   <= div_ctrl.ok;
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_ok;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a failed conversion never carries a value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("failed conversion with nonzero value");

    // a result not taken must still be offered next cycle
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output result dropped under stall");

    // input is refused only when a waiting result blocks a finished one
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("pipeline stalled without a blocked output");
`endif

endmodule

`default_nettype wire
